// ----- hdl/dssm_pkg.sv -----
// Shared types and constants of the drive safety supervisor.
// State codes, event codes, fault bit masks and the register layout.
// Depends on nothing; every other file refers to it by scoped names.
package dssm_pkg;

  localparam int ST_W   = 3;
  localparam int CMD_W  = 3;
  localparam int MODE_W = 2;
  localparam int VEL_W  = 16;
  localparam int LIM_W  = 15;
  localparam int FLT_W  = 16;
  localparam int SEQ_W  = 8;
  localparam int TIME_W = 32;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int NWHEEL = 4;

  // run states
  localparam logic [ST_W-1:0] ST_SELF_TEST = 3'd0;
  localparam logic [ST_W-1:0] ST_SAFE_IDLE = 3'd1;
  localparam logic [ST_W-1:0] ST_ARMED     = 3'd2;
  localparam logic [ST_W-1:0] ST_ACTIVE    = 3'd3;
  localparam logic [ST_W-1:0] ST_FAULT     = 3'd4;

  // event codes
  localparam logic [CMD_W-1:0] CMD_SELF_TEST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MODE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_VELOCITY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ESTOP     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FAULT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd5;

  // mode requests
  localparam logic [MODE_W-1:0] MODE_ARM       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAFE_IDLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd2;

  // fault word bits
  localparam logic [FLT_W-1:0] FB_INTERNAL = 16'h0001;
  localparam logic [FLT_W-1:0] FB_ESTOP    = 16'h0002;
  localparam logic [FLT_W-1:0] FB_TIMEOUT  = 16'h0004;

  // register indexes (word address = paddr[2])
  localparam logic REG_VEL_LIMIT = 1'b0;
  localparam logic REG_WDOG      = 1'b1;

  typedef struct packed {
    logic [LIM_W-1:0]  vel_limit;
    logic [TIME_W-1:0] wdog_period;
  } cfg_t;

endpackage

// ----- hdl/dssm_if.sv -----
// Valid/ready channel interfaces of the drive safety supervisor.
// dssm_in_if carries one event item, dssm_out_if one result item.
// Widths come from dssm_pkg.
interface dssm_in_if;
  logic                              valid;
  logic                              ready;
  logic [dssm_pkg::CMD_W-1:0]        cmd;
  logic                              flag;
  logic [dssm_pkg::MODE_W-1:0]       mode;
  logic signed [dssm_pkg::VEL_W-1:0] vel_0;
  logic signed [dssm_pkg::VEL_W-1:0] vel_1;
  logic signed [dssm_pkg::VEL_W-1:0] vel_2;
  logic signed [dssm_pkg::VEL_W-1:0] vel_3;
  logic [dssm_pkg::SEQ_W-1:0]        seq;
  logic [dssm_pkg::FLT_W-1:0]        fault_in;
  logic [dssm_pkg::TIME_W-1:0]       now_ms;

  modport source (output valid, cmd, flag, mode, vel_0, vel_1, vel_2, vel_3,
                  seq, fault_in, now_ms, input ready);
  modport sink   (input valid, cmd, flag, mode, vel_0, vel_1, vel_2, vel_3,
                  seq, fault_in, now_ms, output ready);
endinterface

interface dssm_out_if;
  logic                              valid;
  logic                              ready;
  logic [dssm_pkg::ST_W-1:0]         cur_state;
  logic [dssm_pkg::FLT_W-1:0]        fault_bits_out;
  logic                              estop_out;
  logic                              accepted;
  logic                              motion_allowed;
  logic signed [dssm_pkg::VEL_W-1:0] target_0;
  logic signed [dssm_pkg::VEL_W-1:0] target_1;
  logic signed [dssm_pkg::VEL_W-1:0] target_2;
  logic signed [dssm_pkg::VEL_W-1:0] target_3;
  logic [dssm_pkg::SEQ_W-1:0]        seq_echo;

  modport source (output valid, cur_state, fault_bits_out, estop_out, accepted,
                  motion_allowed, target_0, target_1, target_2, target_3,
                  seq_echo, input ready);
  modport sink   (input valid, cur_state, fault_bits_out, estop_out, accepted,
                  motion_allowed, target_0, target_1, target_2, target_3,
                  seq_echo, output ready);
endinterface

// ----- hdl/drive_safety_state_machine_core.sv -----
// Top level of the drive safety supervisor for a four-wheel drive.
// Uses dssm_pkg, dssm_if (channels), dssm_cfg_regs and dssm_clamp.
//
// Usage:
//  - in_ch carries one event item (self test, mode, velocity, e-stop,
//    raise fault, tick); out_ch returns exactly one result item per event.
//  - An item is taken when valid and ready are both high at a clock edge.
//  - The result is registered: it is valid the cycle after the event is taken.
//  - Throughput: one item per cycle while out_ch.ready keeps up. The state update is one shallow pass
//    (clamps, a 32-bit elapsed-time subtract and compare) from the event
//    port straight into the state and result registers.
//  - The result register parts the two sides: in_ch.ready stays high while
//    the result register is empty or is being drained in the same cycle.
//    A stalled receiver holds the result and blocks only the next event.
//  - Registers via psel/penable/pwrite/paddr/pwdata: velocity_limit at 0x0,
//    watchdog_period at 0x4. pready is tied high. Write only while idle.
//  - Reset (rst_n low, synchronous): state self test, fault word, e-stop
//    latch, sequence echo, last command time, targets and registers zero;
//    no result pending.
module drive_safety_state_machine_core (
  input  logic                        clk,
  input  logic                        rst_n,
  dssm_in_if.sink                     in_ch,
  dssm_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dssm_pkg::ADDR_W-1:0] paddr,
  input  logic [dssm_pkg::DATA_W-1:0] pwdata,
  output logic [dssm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  dssm_pkg::cfg_t cfg;

  // supervisor state
  logic [dssm_pkg::ST_W-1:0]         state_r, state_nxt;
  logic [dssm_pkg::FLT_W-1:0]        fault_r, fault_nxt;
  logic                              estop_r, estop_nxt;
  logic [dssm_pkg::SEQ_W-1:0]        seq_r, seq_nxt;
  logic [dssm_pkg::TIME_W-1:0]       last_r, last_nxt;
  logic signed [dssm_pkg::VEL_W-1:0] tgt_r   [dssm_pkg::NWHEEL];
  logic signed [dssm_pkg::VEL_W-1:0] tgt_nxt [dssm_pkg::NWHEEL];

  logic signed [dssm_pkg::VEL_W-1:0] vel_in  [dssm_pkg::NWHEEL];
  logic signed [dssm_pkg::VEL_W-1:0] clamped [dssm_pkg::NWHEEL];
  logic [dssm_pkg::TIME_W-1:0]       elapsed;
  logic                              acc_nxt;
  logic                              zero_tgt;
  logic                              in_fire;

  // result register
  logic                              out_valid_r;
  logic [dssm_pkg::ST_W-1:0]         res_state_r;
  logic [dssm_pkg::FLT_W-1:0]        res_fault_r;
  logic                              res_estop_r;
  logic                              res_acc_r;
  logic                              res_motion_r;
  logic signed [dssm_pkg::VEL_W-1:0] res_tgt_r [dssm_pkg::NWHEEL];
  logic [dssm_pkg::SEQ_W-1:0]        res_seq_r;

  dssm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign vel_in[0] = in_ch.vel_0;
  assign vel_in[1] = in_ch.vel_1;
  assign vel_in[2] = in_ch.vel_2;
  assign vel_in[3] = in_ch.vel_3;

  for (genvar w = 0; w < dssm_pkg::NWHEEL; w++) begin : g_clamp
    dssm_clamp u_clamp (
      .vel         (vel_in[w]),
      .lim         (cfg.vel_limit),
      .vel_clamped (clamped[w])
    );
  end

  // skid-free: take an event whenever the result slot is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // wrapping elapsed time since the last applied velocity command
  assign elapsed = in_ch.now_ms - last_r;

  always_comb begin
    state_nxt = state_r;
    fault_nxt = fault_r;
    estop_nxt = estop_r;
    seq_nxt   = seq_r;
    last_nxt  = last_r;
    tgt_nxt   = tgt_r;
    acc_nxt   = 1'b0;
    zero_tgt  = 1'b0;
    unique case (in_ch.cmd)
      dssm_pkg::CMD_SELF_TEST: begin
        // only meaningful while still in self test
        if (state_r == dssm_pkg::ST_SELF_TEST) begin
          if (in_ch.flag) begin
            state_nxt = dssm_pkg::ST_SAFE_IDLE;
          end else begin
            fault_nxt = fault_r | dssm_pkg::FB_INTERNAL;
            state_nxt = dssm_pkg::ST_FAULT;
          end
        end
      end
      dssm_pkg::CMD_MODE: begin
        // mode requests are locked out under e-stop
        if (!estop_r) begin
          unique case (in_ch.mode)
            dssm_pkg::MODE_ARM: begin
              if (state_r == dssm_pkg::ST_SAFE_IDLE) begin
                state_nxt = dssm_pkg::ST_ARMED;
              end
            end
            dssm_pkg::MODE_SAFE_IDLE: begin
              if (state_r == dssm_pkg::ST_ARMED || state_r == dssm_pkg::ST_ACTIVE) begin
                zero_tgt  = 1'b1;
                state_nxt = dssm_pkg::ST_SAFE_IDLE;
              end
            end
            dssm_pkg::MODE_CLEAR: begin
              if (state_r == dssm_pkg::ST_FAULT) begin
                fault_nxt = '0;
                zero_tgt  = 1'b1;
                state_nxt = dssm_pkg::ST_SAFE_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dssm_pkg::CMD_VELOCITY: begin
        // armed goes active on the first command, then the command applies
        if (!estop_r &&
            (state_r == dssm_pkg::ST_ARMED || state_r == dssm_pkg::ST_ACTIVE)) begin
          state_nxt = dssm_pkg::ST_ACTIVE;
          tgt_nxt   = clamped;
          seq_nxt   = in_ch.seq;
          last_nxt  = in_ch.now_ms;
          acc_nxt   = 1'b1;
        end
      end
      dssm_pkg::CMD_ESTOP: begin
        estop_nxt = in_ch.flag;
        if (in_ch.flag) begin
          fault_nxt = fault_r | dssm_pkg::FB_ESTOP;
          zero_tgt  = 1'b1;
          state_nxt = dssm_pkg::ST_FAULT;
        end else begin
          // release leaves the state alone
          fault_nxt = fault_r & ~dssm_pkg::FB_ESTOP;
        end
      end
      dssm_pkg::CMD_FAULT: begin
        // enters fault even with an empty mask
        fault_nxt = fault_r | in_ch.fault_in;
        zero_tgt  = 1'b1;
        state_nxt = dssm_pkg::ST_FAULT;
      end
      dssm_pkg::CMD_TICK: begin
        // watchdog: strictly greater than the period
        if (state_r == dssm_pkg::ST_ACTIVE && elapsed > cfg.wdog_period) begin
          fault_nxt = fault_r | dssm_pkg::FB_TIMEOUT;
          zero_tgt  = 1'b1;
          state_nxt = dssm_pkg::ST_SAFE_IDLE;
        end
      end
      default: begin
        // unused codes only report
      end
    endcase
    if (zero_tgt) begin
      for (int i = 0; i < dssm_pkg::NWHEEL; i++) begin
        tgt_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dssm_pkg::ST_SELF_TEST;
      fault_r <= '0;
      estop_r <= 1'b0;
      seq_r   <= '0;
      last_r  <= '0;
      for (int i = 0; i < dssm_pkg::NWHEEL; i++) begin
        tgt_r[i] <= '0;
      end
    end else if (in_fire) begin
      state_r <= state_nxt;
      fault_r <= fault_nxt;
      estop_r <= estop_nxt;
      seq_r   <= seq_nxt;
      last_r  <= last_nxt;
      tgt_r   <= tgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with the post-event state
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_state_r  <= state_nxt;
      res_fault_r  <= fault_nxt;
      res_estop_r  <= estop_nxt;
      res_acc_r    <= acc_nxt;
      res_motion_r <= (state_nxt == dssm_pkg::ST_ACTIVE) && !estop_nxt;
      res_tgt_r    <= tgt_nxt;
      res_seq_r    <= seq_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cur_state      = res_state_r;
  assign out_ch.fault_bits_out = res_fault_r;
  assign out_ch.estop_out      = res_estop_r;
  assign out_ch.accepted       = res_acc_r;
  assign out_ch.motion_allowed = res_motion_r;
  assign out_ch.target_0       = res_tgt_r[0];
  assign out_ch.target_1       = res_tgt_r[1];
  assign out_ch.target_2       = res_tgt_r[2];
  assign out_ch.target_3       = res_tgt_r[3];
  assign out_ch.seq_echo       = res_seq_r;

`ifndef NO_ASSERTIONS
  // a latched e-stop pins the block in fault with the e-stop bit set
  a_estop_fault: assert property (@(posedge clk) disable iff (!rst_n)
    estop_r |-> (state_r == dssm_pkg::ST_FAULT && (fault_r & dssm_pkg::FB_ESTOP) != '0))
    else $error("e-stop latched outside fault or without its fault bit");

  // targets can be nonzero only while active
  a_tgt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dssm_pkg::ST_ACTIVE) |->
      (tgt_r[0] == '0 && tgt_r[1] == '0 && tgt_r[2] == '0 && tgt_r[3] == '0))
    else $error("wheel targets nonzero outside active");

  // an applied velocity command always reports motion allowed
  a_acc_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_acc_r) |-> res_motion_r)
    else $error("accepted command without motion allowed");
`endif

endmodule

// ----- hdl/dssm_cfg_regs.sv -----
// APB-style register file of the drive safety supervisor.
// Holds velocity_limit and watchdog_period; uses dssm_pkg.
module dssm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dssm_pkg::ADDR_W-1:0]   paddr,
  input  logic [dssm_pkg::DATA_W-1:0]   pwdata,
  output logic [dssm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dssm_pkg::cfg_t                cfg
);

  dssm_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      if (paddr[2] == dssm_pkg::REG_VEL_LIMIT) begin
        cfg_r.vel_limit <= pwdata[dssm_pkg::LIM_W-1:0];
      end else begin
        cfg_r.wdog_period <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[2] == dssm_pkg::REG_WDOG) begin
      prdata = cfg_r.wdog_period;
    end else begin
      prdata = {{(dssm_pkg::DATA_W-dssm_pkg::LIM_W){1'b0}}, cfg_r.vel_limit};
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/dssm_clamp.sv -----
// Symmetric velocity clamp to +/- limit for one wheel.
// Uses widths from dssm_pkg.
module dssm_clamp (
  input  logic signed [dssm_pkg::VEL_W-1:0] vel,
  input  logic        [dssm_pkg::LIM_W-1:0] lim,
  output logic signed [dssm_pkg::VEL_W-1:0] vel_clamped
);

  logic signed [dssm_pkg::VEL_W:0] vel_x;
  logic signed [dssm_pkg::VEL_W:0] lim_x;

  assign vel_x = {vel[dssm_pkg::VEL_W-1], vel};
  assign lim_x = $signed({2'b00, lim});

  always_comb begin
    if (vel_x > lim_x) begin
      vel_clamped = $signed({1'b0, lim});
    end else if (vel_x < -lim_x) begin
      vel_clamped = -$signed({1'b0, lim});
    end else begin
      vel_clamped = vel;
    end
  end

endmodule

// ----- tb/sv/drive_safety_state_machine_core_tb.sv -----
// Self-checking testbench for drive_safety_state_machine_core.
// Drives events and register writes, predicts each result item and checks it.
// Depends on dssm_pkg, dssm_if.sv (channel interfaces) and the core RTL.
module drive_safety_state_machine_core_tb;

  // Event codes and a mode code that the package leaves unnamed
  localparam logic [dssm_pkg::CMD_W-1:0]  CMD_UNUSED_6 = 3'd6;
  localparam logic [dssm_pkg::CMD_W-1:0]  CMD_UNUSED_7 = 3'd7;
  localparam logic [dssm_pkg::MODE_W-1:0] MODE_RSVD    = 2'd3;

  localparam int NUM_SEGMENTS = 8;
  localparam int SEG_ITEMS    = 245;

  // One input item, wheels packed low to high
  typedef struct packed {
    logic [dssm_pkg::CMD_W-1:0]                       cmd;
    logic                                             flag;
    logic [dssm_pkg::MODE_W-1:0]                      mode;
    logic [dssm_pkg::NWHEEL-1:0][dssm_pkg::VEL_W-1:0] vel;
    logic [dssm_pkg::SEQ_W-1:0]                       seq;
    logic [dssm_pkg::FLT_W-1:0]                       fault_in;
    logic [dssm_pkg::TIME_W-1:0]                      now_ms;
  } drive_event_t;

  // One result item
  typedef struct packed {
    logic [dssm_pkg::ST_W-1:0]                        cur_state;
    logic [dssm_pkg::FLT_W-1:0]                       flt_word;
    logic                                             estop;
    logic                                             accepted;
    logic                                             motion;
    logic [dssm_pkg::NWHEEL-1:0][dssm_pkg::VEL_W-1:0] target;
    logic [dssm_pkg::SEQ_W-1:0]                       seq_echo;
  } drive_report_t;

  // Supervisor predictor plus the queue of reports it expects
  class supervisor_sb;
    logic [dssm_pkg::ST_W-1:0]                        state_q;
    logic [dssm_pkg::FLT_W-1:0]                       faults_q;
    logic                                             estop_q;
    logic [dssm_pkg::SEQ_W-1:0]                       seq_q;
    logic [dssm_pkg::TIME_W-1:0]                      cmd_time_q;
    logic [dssm_pkg::NWHEEL-1:0][dssm_pkg::VEL_W-1:0] tgt_q;
    logic [dssm_pkg::LIM_W-1:0]                       lim_r;
    logic [dssm_pkg::TIME_W-1:0]                      wdog_r;
    drive_report_t                pending_reports[$];
    int errors;
    int n_events;
    int n_reports;
    int n_applied;
    int n_timeouts;

    function new();
      state_q    = dssm_pkg::ST_SELF_TEST;
      faults_q   = '0;
      estop_q    = 1'b0;
      seq_q      = '0;
      cmd_time_q = '0;
      tgt_q      = '0;
      lim_r      = '0;
      wdog_r     = '0;
      errors     = 0;
      n_events   = 0;
      n_reports  = 0;
      n_applied  = 0;
      n_timeouts = 0;
    endfunction

    function void set_reg(logic idx, logic [dssm_pkg::DATA_W-1:0] val);
      if (idx == dssm_pkg::REG_VEL_LIMIT) lim_r = val[dssm_pkg::LIM_W-1:0];
      else wdog_r = val;
    endfunction

    function int pending_count();
      return pending_reports.size();
    endfunction

    function logic [dssm_pkg::VEL_W-1:0] clamp_wheel(logic [dssm_pkg::VEL_W-1:0] raw);
      int v;
      int lim;
      v   = int'($signed(raw));
      lim = int'(lim_r);
      if (v > lim) v = lim;
      else if (v < -lim) v = -lim;
      return v[dssm_pkg::VEL_W-1:0];
    endfunction

    function void note_event(drive_event_t e);
      drive_report_t r;
      logic          took;
      logic [dssm_pkg::TIME_W-1:0] elapsed;
      took = 1'b0;
      n_events++;
      case (e.cmd)
        dssm_pkg::CMD_SELF_TEST: begin
          if (state_q == dssm_pkg::ST_SELF_TEST) begin
            if (e.flag) begin
              state_q = dssm_pkg::ST_SAFE_IDLE;
            end else begin
              faults_q |= dssm_pkg::FB_INTERNAL;
              state_q = dssm_pkg::ST_FAULT;
            end
          end
        end
        dssm_pkg::CMD_MODE: begin
          if (!estop_q) begin
            case (e.mode)
              dssm_pkg::MODE_ARM: begin
                if (state_q == dssm_pkg::ST_SAFE_IDLE) state_q = dssm_pkg::ST_ARMED;
              end
              dssm_pkg::MODE_SAFE_IDLE: begin
                if (state_q == dssm_pkg::ST_ARMED || state_q == dssm_pkg::ST_ACTIVE) begin
                  tgt_q   = '0;
                  state_q = dssm_pkg::ST_SAFE_IDLE;
                end
              end
              dssm_pkg::MODE_CLEAR: begin
                if (state_q == dssm_pkg::ST_FAULT) begin
                  faults_q = '0;
                  tgt_q    = '0;
                  state_q  = dssm_pkg::ST_SAFE_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
        dssm_pkg::CMD_VELOCITY: begin
          if (!estop_q) begin
            if (state_q == dssm_pkg::ST_ARMED) state_q = dssm_pkg::ST_ACTIVE;
            if (state_q == dssm_pkg::ST_ACTIVE) begin
              for (int i = 0; i < dssm_pkg::NWHEEL; i++) tgt_q[i] = clamp_wheel(e.vel[i]);
              seq_q      = e.seq;
              cmd_time_q = e.now_ms;
              took       = 1'b1;
              n_applied++;
            end
          end
        end
        dssm_pkg::CMD_ESTOP: begin
          estop_q = e.flag;
          if (e.flag) begin
            faults_q |= dssm_pkg::FB_ESTOP;
            tgt_q   = '0;
            state_q = dssm_pkg::ST_FAULT;
          end else begin
            faults_q &= ~dssm_pkg::FB_ESTOP;
          end
        end
        dssm_pkg::CMD_FAULT: begin
          faults_q |= e.fault_in;
          tgt_q   = '0;
          state_q = dssm_pkg::ST_FAULT;
        end
        dssm_pkg::CMD_TICK: begin
          elapsed = e.now_ms - cmd_time_q;
          if (state_q == dssm_pkg::ST_ACTIVE && elapsed > wdog_r) begin
            faults_q |= dssm_pkg::FB_TIMEOUT;
            tgt_q   = '0;
            state_q = dssm_pkg::ST_SAFE_IDLE;
            n_timeouts++;
          end
        end
        default: ;
      endcase
      r.cur_state  = state_q;
      r.flt_word   = faults_q;
      r.estop      = estop_q;
      r.accepted   = took;
      r.motion     = (state_q == dssm_pkg::ST_ACTIVE) && !estop_q;
      r.target     = tgt_q;
      r.seq_echo   = seq_q;
      pending_reports.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(drive_report_t got);
      drive_report_t want;
      if (pending_reports.size() == 0) begin
        $error("result item arrived with no event outstanding");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      n_reports++;
      check_field("cur_state", want.cur_state, got.cur_state);
      check_field("fault_bits_out", want.flt_word, got.flt_word);
      check_field("estop_out", want.estop, got.estop);
      check_field("accepted", want.accepted, got.accepted);
      check_field("motion_allowed", want.motion, got.motion);
      for (int i = 0; i < dssm_pkg::NWHEEL; i++)
        check_field($sformatf("target_%0d", i), want.target[i], got.target[i]);
      check_field("seq_echo", want.seq_echo, got.seq_echo);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [dssm_pkg::ADDR_W-1:0] paddr;
  logic [dssm_pkg::DATA_W-1:0] pwdata;
  logic [dssm_pkg::DATA_W-1:0] prdata;
  logic pready;

  dssm_in_if  in_ch ();
  dssm_out_if out_ch ();

  supervisor_sb sb;

  // idle percentages of the current phase, read by the driver and the sink
  int send_idle;
  int recv_stall;
  // millisecond clock stamped on velocity commands and ticks
  logic [dssm_pkg::TIME_W-1:0] ms_clock;
  logic [dssm_pkg::LIM_W-1:0]  cur_lim;
  int                          n_settings;

  drive_safety_state_machine_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Hard stop if the block hangs; far beyond any correct run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Result sink: ready changes on the falling edge, items are taken on the
  // rising edge where the pre-edge values are still visible.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    drive_report_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cur_state  = out_ch.cur_state;
      got.flt_word   = out_ch.fault_bits_out;
      got.estop      = out_ch.estop_out;
      got.accepted   = out_ch.accepted;
      got.motion     = out_ch.motion_allowed;
      got.target[0]  = out_ch.target_0;
      got.target[1]  = out_ch.target_1;
      got.target[2]  = out_ch.target_2;
      got.target[3]  = out_ch.target_3;
      got.seq_echo   = out_ch.seq_echo;
      sb.check_report(got);
    end
  end

  // All tasks below start and end right after a falling edge.

  // APB write: setup cycle, then access cycle; pready is tied high so the
  // register takes the value at the rising edge inside the access cycle.
  task automatic write_reg(input logic idx, input logic [dssm_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dssm_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == dssm_pkg::REG_VEL_LIMIT) cur_lim = val[dssm_pkg::LIM_W-1:0];
  endtask

  // Offer one item, with random idle cycles ahead of it, and hold it until
  // the block takes it. valid stays high into the next call.
  task automatic send_event(input drive_event_t e);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= e.cmd;
    in_ch.flag     <= e.flag;
    in_ch.mode     <= e.mode;
    in_ch.vel_0    <= e.vel[0];
    in_ch.vel_1    <= e.vel[1];
    in_ch.vel_2    <= e.vel[2];
    in_ch.vel_3    <= e.vel[3];
    in_ch.seq      <= e.seq;
    in_ch.fault_in <= e.fault_in;
    in_ch.now_ms   <= e.now_ms;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(e);
    @(negedge clk);
  endtask

  // Drop valid, wait until every report has come back, then leave the block
  // idle before returning.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Fields a command does not use carry random noise
  function automatic drive_event_t noise_event();
    drive_event_t e;
    e.cmd      = 3'($urandom);
    e.flag     = 1'($urandom);
    e.mode     = 2'($urandom);
    for (int i = 0; i < dssm_pkg::NWHEEL; i++) e.vel[i] = 16'($urandom);
    e.seq      = 8'($urandom);
    e.fault_in = 16'($urandom);
    e.now_ms   = $urandom;
    return e;
  endfunction

  task automatic do_cmd(input logic [dssm_pkg::CMD_W-1:0] c);
    drive_event_t e;
    e = noise_event();
    e.cmd = c;
    send_event(e);
  endtask

  task automatic do_selftest(input logic ok);
    drive_event_t e;
    e = noise_event();
    e.cmd  = dssm_pkg::CMD_SELF_TEST;
    e.flag = ok;
    send_event(e);
  endtask

  task automatic do_mode(input logic [dssm_pkg::MODE_W-1:0] m);
    drive_event_t e;
    e = noise_event();
    e.cmd  = dssm_pkg::CMD_MODE;
    e.mode = m;
    send_event(e);
  endtask

  task automatic do_vel(input logic [dssm_pkg::VEL_W-1:0]  v0,
                        input logic [dssm_pkg::VEL_W-1:0]  v1,
                        input logic [dssm_pkg::VEL_W-1:0]  v2,
                        input logic [dssm_pkg::VEL_W-1:0]  v3,
                        input logic [dssm_pkg::SEQ_W-1:0]  s,
                        input logic [dssm_pkg::TIME_W-1:0] now);
    drive_event_t e;
    e = noise_event();
    e.cmd    = dssm_pkg::CMD_VELOCITY;
    e.vel[0] = v0;
    e.vel[1] = v1;
    e.vel[2] = v2;
    e.vel[3] = v3;
    e.seq    = s;
    e.now_ms = now;
    send_event(e);
  endtask

  task automatic do_estop(input logic on);
    drive_event_t e;
    e = noise_event();
    e.cmd  = dssm_pkg::CMD_ESTOP;
    e.flag = on;
    send_event(e);
  endtask

  task automatic do_fault(input logic [dssm_pkg::FLT_W-1:0] bits);
    drive_event_t e;
    e = noise_event();
    e.cmd      = dssm_pkg::CMD_FAULT;
    e.fault_in = bits;
    send_event(e);
  endtask

  task automatic do_tick(input logic [dssm_pkg::TIME_W-1:0] now);
    drive_event_t e;
    e = noise_event();
    e.cmd    = dssm_pkg::CMD_TICK;
    e.now_ms = now;
    send_event(e);
  endtask

  // Wheel request biased toward the clamp edges and the 16-bit extremes
  function automatic logic [dssm_pkg::VEL_W-1:0] rand_vel();
    case ($urandom_range(11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(cur_lim);
      3: return -16'(cur_lim);
      4: return 16'(cur_lim) + 16'd1;
      5: return -16'(cur_lim) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Time mostly creeps forward around the short watchdog periods; now and
  // then it leaps far ahead so long periods can expire too.
  task automatic advance_clock();
    if ($urandom_range(19) == 0) ms_clock += $urandom;
    else ms_clock += $urandom_range(60);
  endtask

  // Mostly arm / command / tick traffic that keeps the block moving through
  // armed and active, with e-stops, raised faults and junk codes mixed in.
  task automatic random_event();
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 4) begin
      do_selftest($urandom_range(3) != 0);
    end else if (r < 26) begin
      k = $urandom_range(9);
      if (k < 4) do_mode(dssm_pkg::MODE_ARM);
      else if (k < 6) do_mode(dssm_pkg::MODE_SAFE_IDLE);
      else if (k < 9) do_mode(dssm_pkg::MODE_CLEAR);
      else do_mode(MODE_RSVD);
    end else if (r < 60) begin
      advance_clock();
      do_vel(rand_vel(), rand_vel(), rand_vel(), rand_vel(), 8'($urandom), ms_clock);
    end else if (r < 64) begin
      do_estop($urandom_range(3) == 0);
    end else if (r < 68) begin
      do_fault(($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom));
    end else if (r < 95) begin
      advance_clock();
      do_tick(ms_clock);
    end else begin
      do_cmd($urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7);
    end
  endtask

  initial begin
    logic [dssm_pkg::LIM_W-1:0]  lim_set  [NUM_SEGMENTS];
    logic [dssm_pkg::TIME_W-1:0] wdog_set [NUM_SEGMENTS];
    int                          idle_set [4];
    int                          stall_set[4];

    sb = new();
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = '0;
    in_ch.flag     = 1'b0;
    in_ch.mode     = '0;
    in_ch.vel_0    = '0;
    in_ch.vel_1    = '0;
    in_ch.vel_2    = '0;
    in_ch.vel_3    = '0;
    in_ch.seq      = '0;
    in_ch.fault_in = '0;
    in_ch.now_ms   = '0;
    send_idle      = 0;
    recv_stall     = 0;
    ms_clock       = '0;
    cur_lim        = '0;
    n_settings     = 0;

    // extremes first, then mid values, one random pair
    lim_set  = '{15'd0, 15'd32767, 15'd1000, 15'd1, 15'd20000,
                 15'($urandom_range(32767)), 15'd300, 15'd32767};
    wdog_set = '{32'd0, 32'hFFFF_FFFF, 32'd50, 32'd1, 32'd200,
                 $urandom, 32'd20, 32'd5};
    // none, sender idle, receiver stall, both
    idle_set  = '{0, 56, 0, 29};
    stall_set = '{0, 0, 56, 29};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part: limit 1000, watchdog 100 ms ----
    write_reg(dssm_pkg::REG_VEL_LIMIT, 32'd1000);
    write_reg(dssm_pkg::REG_WDOG, 32'd100);
    n_settings++;

    do_cmd(CMD_UNUSED_7);                // junk code while in self test
    do_mode(dssm_pkg::MODE_ARM);         // arm not allowed from self test
    do_selftest(1'b0);                   // failed self test: internal bit, fault
    do_selftest(1'b1);                   // self test outside self test: ignored
    do_mode(dssm_pkg::MODE_ARM);         // arm from fault: ignored
    do_mode(dssm_pkg::MODE_CLEAR);       // clear: fault word zero, safe idle
    do_mode(MODE_RSVD);                  // unknown mode: ignored
    do_mode(dssm_pkg::MODE_ARM);         // safe idle -> armed
    // armed -> active; wheels clamp high, clamp low, stay just inside, and clamp just below -1000
    do_vel(16'h7FFF, 16'h8000, 16'd999, 16'(-1001), 8'hFF, 32'd10);
    do_tick(32'd110);                    // elapsed equals period: no timeout
    do_tick(32'd111);                    // one past the period: timeout
    do_mode(dssm_pkg::MODE_ARM);
    do_vel(16'd1000, 16'(-1000), 16'd0, 16'd1, 8'h00, 32'hFFFF_FFF0);
    do_tick(32'h0000_0050);              // elapsed wraps through zero: 96 ms
    do_estop(1'b1);                      // e-stop forces fault
    do_mode(dssm_pkg::MODE_CLEAR);       // mode under e-stop: ignored
    do_vel(16'd5, 16'd5, 16'd5, 16'd5, 8'h11, 32'd200);  // ignored under e-stop
    do_estop(1'b0);                      // release clears the bit, stays in fault
    do_fault(16'hFFFF);
    do_mode(dssm_pkg::MODE_CLEAR);
    do_fault(16'h0000);                  // zero mask still enters fault
    do_mode(dssm_pkg::MODE_CLEAR);
    do_mode(dssm_pkg::MODE_SAFE_IDLE);   // safe idle from safe idle: ignored
    do_cmd(CMD_UNUSED_6);
    settle();

    // ---- random part: each idle profile under two register settings ----
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      write_reg(dssm_pkg::REG_VEL_LIMIT, dssm_pkg::DATA_W'(lim_set[seg]));
      write_reg(dssm_pkg::REG_WDOG, wdog_set[seg]);
      n_settings++;
      send_idle  = idle_set[seg % 4];
      recv_stall = stall_set[seg % 4];
      // some segments start just short of the 32-bit wrap
      if (seg % 4 == 1) ms_clock = 32'hFFFF_FF00;
      for (int n = 0; n < SEG_ITEMS; n++) random_event();
      settle();
    end

    $display("Run covered %0d events and %0d checked results under %0d register settings,",
             sb.n_events, sb.n_reports, n_settings);
    $display("with %0d velocity commands applied and %0d watchdog timeouts.",
             sb.n_applied, sb.n_timeouts);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
